// ===== src/mic_pkg.sv =====
// ----------------------------------------------------------------------------
// mic_pkg - shared types and constants
// Opcodes, function codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package mic_pkg;

	localparam int DMEM_WORDS = 4096;               // power of two
	localparam int DMEM_AW    = $clog2(DMEM_WORDS);
	localparam int RF_DEPTH   = 32;
	localparam int DIV_STEPS  = 32;

	localparam logic [5:0] OP_RTYPE  = 6'd0;
	localparam logic [5:0] OP_J      = 6'd2;
	localparam logic [5:0] OP_JAL    = 6'd3;
	localparam logic [5:0] OP_BEQ    = 6'd4;
	localparam logic [5:0] OP_BNE    = 6'd5;
	localparam logic [5:0] OP_ADDI   = 6'd8;
	localparam logic [5:0] OP_ADDI_U = 6'd9;
	localparam logic [5:0] OP_SLTI   = 6'd10;
	localparam logic [5:0] OP_SLTI_U = 6'd11;
	localparam logic [5:0] OP_ANDI   = 6'd12;
	localparam logic [5:0] OP_ORI    = 6'd13;
	localparam logic [5:0] OP_LUI    = 6'd15;
	localparam logic [5:0] OP_LW     = 6'd35;
	localparam logic [5:0] OP_LBU    = 6'd36;
	localparam logic [5:0] OP_LHU    = 6'd37;
	localparam logic [5:0] OP_SB     = 6'd40;
	localparam logic [5:0] OP_SH     = 6'd41;
	localparam logic [5:0] OP_SW     = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SRA     = 6'd3;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_MULTU   = 6'd25;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_DIVU    = 6'd27;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;
	localparam logic [5:0] FN_SLTU    = 6'd43;

	localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
	localparam logic [31:0] SYS_EXIT       = 32'd10;
	localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;
	localparam logic [4:0]  REG_V0         = 5'd2;
	localparam logic [4:0]  REG_A0         = 5'd4;
	localparam logic [4:0]  REG_RA         = 5'd31;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_INT   = 2'd1,
		EV_CHAR  = 2'd2,
		EV_HALT  = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		K_PLAIN = 2'd0,
		K_MEM   = 2'd1,
		K_MUL   = 2'd2,
		K_DIV   = 2'd3
	} kind_t;

	typedef struct packed {
		logic clr;       // clearing pass step
		logic accept;    // instruction transaction taken
		logic halt_out;  // input ignored after halt
		logic latch_ops; // capture register operands
		logic exec;      // decode and commit simple ops
		logic mem_fin;   // finish load or store
		logic mul_fin;   // write product to HI/LO
		logic div_step;  // one divider iteration
		logic div_fin;   // write quotient and remainder
		logic cfg_wr;    // boot address write
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  halted;
		logic  clr_last;
		logic  div_done;
	} stat_t;

endpackage

// ===== src/mic_ram.sv =====
// ----------------------------------------------------------------------------
// mic_ram - generic single-port RAM
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module mic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== src/mic_ctrl.sv =====
// ----------------------------------------------------------------------------
// mic_ctrl - sequencing state machine
// Steps each instruction through read, execute and the multicycle paths.
// ----------------------------------------------------------------------------
module mic_ctrl
	import mic_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_READ = 8'b0000_0100,
		S_EXEC = 8'b0000_1000,
		S_MEM  = 8'b0001_0000,
		S_MUL  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid  = (state_q == S_DONE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				cmd.cfg_wr = cfg_valid;
				if (s_tvalid) begin
					cmd.accept   = 1'b1;
					cmd.halt_out = stat.halted;
					state_nx     = stat.halted ? S_DONE : S_READ;
				end
			end
			S_READ: begin
				cmd.latch_ops = 1'b1;
				state_nx      = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (stat.kind)
					K_MEM:   state_nx = S_MEM;
					K_MUL:   state_nx = S_MUL;
					K_DIV:   state_nx = S_DIV;
					default: state_nx = S_DONE;
				endcase
			end
			S_MEM: begin
				cmd.mem_fin = 1'b1;
				state_nx    = S_DONE;
			end
			S_MUL: begin
				cmd.mul_fin = 1'b1;
				state_nx    = S_DONE;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_fin = 1'b1;
					state_nx    = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DONE: begin
				if (m_tready) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== src/mic_dp.sv =====
// ----------------------------------------------------------------------------
// mic_dp - integer datapath
// Register file, HI/LO, multiplier, iterative divider and data memory.
// ----------------------------------------------------------------------------
module mic_dp
	import mic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [31:0] instr,
	input  logic [31:0] cfg_data,
	output stat_t       stat,
	output logic [31:0] fetch_addr,
	output logic        wb_valid,
	output logic [4:0]  wb_reg,
	output logic [31:0] wb_value,
	output logic [1:0]  event_kind,
	output logic [31:0] event_value
);

	logic [31:0] instr_q, a_q, b_q, pc_q, hi_q, lo_q, v0_q, a0_q, addr_q;
	logic [RF_DEPTH-1:0] rv_q;
	logic        halted_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [5:0]  dcnt_q;
	logic        qneg_q, rneg_q, dz_q;
	logic [DMEM_AW-1:0] clr_q;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] imm, simm, npc, eff;
	logic [31:0] rs_rd, rt_rd, dm_rd;

	assign op   = instr_q[31:26];
	assign rs   = instr_q[25:21];
	assign rt   = instr_q[20:16];
	assign rd   = instr_q[15:11];
	assign sa   = instr_q[10:6];
	assign fn   = instr_q[5:0];
	assign imm  = {16'd0, instr_q[15:0]};
	assign simm = {{16{instr_q[15]}}, instr_q[15:0]};
	assign npc  = pc_q + 32'd4;
	assign eff  = a_q + simm;

	// decode of the operations that complete in the execute state, and of the kind
	kind_t       kind;
	logic        p_we, p_halt;
	logic [4:0]  p_idx;
	logic [31:0] p_val, p_pc, p_evv;
	event_t      p_ev;

	always_comb begin
		kind   = K_PLAIN;
		p_we   = 1'b0;
		p_idx  = rt;
		p_val  = '0;
		p_pc   = npc;
		p_ev   = EV_NONE;
		p_evv  = '0;
		p_halt = 1'b0;
		if (op == OP_RTYPE) begin
			p_idx = rd;
			case (fn)
				FN_SLL:  begin p_we = 1'b1; p_val = b_q << sa; end
				FN_SRL:  begin p_we = 1'b1; p_val = b_q >> sa; end
				FN_SRA:  begin p_we = 1'b1; p_val = 32'($signed(b_q) >>> sa); end
				FN_JR:   p_pc = a_q;
				FN_SYSCALL: begin
					if (v0_q == SYS_PRINT_INT) begin
						p_ev = EV_INT; p_evv = a0_q;
					end else if (v0_q == SYS_PRINT_CHAR) begin
						p_ev = EV_CHAR; p_evv = a0_q;
					end else if (v0_q == SYS_EXIT) begin
						p_ev = EV_HALT; p_halt = 1'b1;
					end
				end
				FN_MFHI: begin p_we = 1'b1; p_val = hi_q; end
				FN_MFLO: begin p_we = 1'b1; p_val = lo_q; end
				FN_MULT, FN_MULTU: kind = K_MUL;
				FN_DIV, FN_DIVU:   kind = K_DIV;
				FN_ADD, FN_ADDU:   begin p_we = 1'b1; p_val = a_q + b_q; end
				FN_SUB, FN_SUBU:   begin p_we = 1'b1; p_val = a_q - b_q; end
				FN_AND:  begin p_we = 1'b1; p_val = a_q & b_q; end
				FN_OR:   begin p_we = 1'b1; p_val = a_q | b_q; end
				FN_NOR:  begin p_we = 1'b1; p_val = ~(a_q | b_q); end
				FN_SLT:  begin p_we = 1'b1; p_val = {31'd0, $signed(a_q) < $signed(b_q)}; end
				FN_SLTU: begin p_we = 1'b1; p_val = {31'd0, a_q < b_q}; end
				default: ;
			endcase
		end else begin
			case (op)
				OP_J: p_pc = {npc[31:28], instr_q[25:0], 2'b00};
				OP_JAL: begin
					p_we = 1'b1; p_idx = REG_RA; p_val = npc;
					p_pc = {npc[31:28], instr_q[25:0], 2'b00};
				end
				OP_BEQ:  if (a_q == b_q) p_pc = npc + {simm[29:0], 2'b00};
				OP_BNE:  if (a_q != b_q) p_pc = npc + {simm[29:0], 2'b00};
				OP_ADDI, OP_ADDI_U: begin p_we = 1'b1; p_val = eff; end
				OP_SLTI:   begin p_we = 1'b1; p_val = {31'd0, $signed(a_q) < $signed(simm)}; end
				OP_SLTI_U: begin p_we = 1'b1; p_val = {31'd0, a_q < simm}; end
				OP_ANDI:  begin p_we = 1'b1; p_val = a_q & imm; end
				OP_ORI:   begin p_we = 1'b1; p_val = a_q | imm; end
				OP_LUI:   begin p_we = 1'b1; p_val = {instr_q[15:0], 16'd0}; end
				OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: kind = K_MEM;
				default: ;
			endcase
		end
		if (p_idx == 5'd0) p_we = 1'b0;
	end

	// memory access: load extract and store merge
	logic        is_load;
	logic [31:0] ld_val, st_word;

	assign is_load = (op == OP_LW) || (op == OP_LBU) || (op == OP_LHU);

	always_comb begin
		st_word = dm_rd;
		case (op)
			OP_LBU:  ld_val = {24'd0, dm_rd[8*(3-addr_q[1:0]) +: 8]};
			OP_LHU:  ld_val = addr_q[1] ? {16'd0, dm_rd[15:0]} : {16'd0, dm_rd[31:16]};
			default: ld_val = dm_rd;
		endcase
		case (op)
			OP_SB:   st_word[8*(3-addr_q[1:0]) +: 8] = b_q[7:0];
			OP_SH:   if (addr_q[1]) st_word[15:0] = b_q[15:0];
			         else st_word[31:16] = b_q[15:0];
			default: st_word = b_q;
		endcase
	end

	// register file write
	logic        rf_we, res_wr;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;

	assign rf_we = (cmd.exec && kind == K_PLAIN && p_we) ||
	               (cmd.mem_fin && is_load && rt != 5'd0);
	assign rf_wa = cmd.mem_fin ? rt : p_idx;
	assign rf_wd = cmd.mem_fin ? ld_val : p_val;
	assign res_wr = (cmd.exec && kind == K_PLAIN) || cmd.mem_fin || cmd.mul_fin
	                || cmd.div_fin;

	mic_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_rs (
		.clk(clk), .we(rf_we), .addr(cmd.accept ? instr[25:21] : rf_wa),
		.wdata(rf_wd), .rdata(rs_rd)
	);
	mic_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_rt (
		.clk(clk), .we(rf_we), .addr(cmd.accept ? instr[20:16] : rf_wa),
		.wdata(rf_wd), .rdata(rt_rd)
	);

	logic               dm_we;
	logic [DMEM_AW-1:0] dm_a;

	assign dm_we = cmd.clr || (cmd.mem_fin && !is_load);
	assign dm_a  = cmd.clr ? clr_q : cmd.mem_fin ? addr_q[DMEM_AW+1:2] : eff[DMEM_AW+1:2];

	mic_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
		.clk(clk), .we(dm_we), .addr(dm_a),
		.wdata(cmd.clr ? 32'd0 : st_word), .rdata(dm_rd)
	);

	// divider
	logic        dsgn;
	logic [31:0] ma, mb;
	logic [32:0] rsh, dif;

	assign dsgn = (fn == FN_DIV);
	assign ma   = (dsgn && a_q[31]) ? 32'd0 - a_q : a_q;
	assign mb   = (dsgn && b_q[31]) ? 32'd0 - b_q : b_q;
	assign rsh  = {rem_q, quo_q[31]};
	assign dif  = rsh - {1'b0, dvs_q};

	assign stat.kind     = kind;
	assign stat.halted   = halted_q;
	assign stat.clr_last = (clr_q == DMEM_AW'(DMEM_WORDS - 1));
	assign stat.div_done = (dcnt_q == 6'(DIV_STEPS));

	function automatic logic dsgn_m(input logic [5:0] f);
		return (f == FN_MULT);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.accept) instr_q <= instr;
		if (cmd.latch_ops) begin
			a_q <= rv_q[rs] ? rs_rd : 32'd0;
			b_q <= rv_q[rt] ? rt_rd : 32'd0;
		end
		if (cmd.exec) begin
			addr_q <= eff;
			prod_q <= 64'($signed({dsgn_m(fn) & a_q[31], a_q}) *
			              $signed({dsgn_m(fn) & b_q[31], b_q}));
			quo_q  <= ma;
			rem_q  <= '0;
			dvs_q  <= mb;
			qneg_q <= dsgn && (a_q[31] ^ b_q[31]);
			rneg_q <= dsgn && a_q[31];
			dz_q   <= (b_q == 32'd0);
		end
		if (cmd.div_step) begin
			if (!dif[32]) begin
				rem_q <= dif[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rsh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			v0_q        <= '0;
			a0_q        <= '0;
			rv_q        <= '0;
			halted_q    <= 1'b0;
			clr_q       <= '0;
			dcnt_q      <= '0;
			fetch_addr  <= '0;
			wb_valid    <= 1'b0;
			wb_reg      <= '0;
			wb_value    <= '0;
			event_kind  <= EV_NONE;
			event_value <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.cfg_wr) pc_q <= {cfg_data[31:2], 2'b00};
			if (cmd.exec) dcnt_q <= '0;
			if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
			if (rf_we) begin
				rv_q[rf_wa] <= 1'b1;
				if (rf_wa == REG_V0) v0_q <= rf_wd;
				if (rf_wa == REG_A0) a0_q <= rf_wd;
			end
			if (cmd.mul_fin) begin
				hi_q <= prod_q[63:32];
				lo_q <= prod_q[31:0];
			end
			if (cmd.div_fin && !dz_q) begin
				lo_q <= qneg_q ? 32'd0 - quo_q : quo_q;
				hi_q <= rneg_q ? 32'd0 - rem_q : rem_q;
			end
			if (cmd.halt_out) begin
				fetch_addr  <= pc_q;
				wb_valid    <= 1'b0;
				wb_reg      <= '0;
				wb_value    <= '0;
				event_kind  <= EV_HALT;
				event_value <= '0;
			end
			if (res_wr) begin
				fetch_addr  <= cmd.exec ? p_pc : npc;
				pc_q        <= cmd.exec ? p_pc : npc;
				wb_valid    <= rf_we;
				wb_reg      <= rf_we ? rf_wa : 5'd0;
				wb_value    <= rf_we ? rf_wd : 32'd0;
				event_kind  <= cmd.exec ? p_ev : EV_NONE;
				event_value <= cmd.exec ? p_evv : 32'd0;
				if (cmd.exec && p_halt) halted_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/mips_integer_core_step.sv =====
// ----------------------------------------------------------------------------
// mips_integer_core_step - multicycle MIPS32 integer core
// Executes one instruction word per input transaction and returns one result.
// ----------------------------------------------------------------------------
// Each accepted instruction passes the read and execute states; loads, stores and
// multiplies add a finishing state (second data memory access or product register),
// divides 32 restoring iterations and a sign fix-up; after halt, a word skips them all.
// Throughput: one transaction at a time; the next is taken the cycle after
// the result transaction completes. Reset clears the data memory in a pass
// over all DMEM_WORDS (4096) words; no instruction is taken until it ends.
module mips_integer_core_step
	import mic_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// instruction stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] instr_word
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] fetch_addr, [32] wb_valid, [37:33] wb_reg, [69:38] wb_value,
	// [101:70] event_value, [103:102] zero
	output logic [103:0] m_tdata,
	output logic [1:0]   m_tuser,   // [1:0] event_kind
	// boot address write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	logic [31:0] fetch_addr, wb_value, event_value;
	logic        wb_valid;
	logic [4:0]  wb_reg;

	// Sequence each instruction: read operands, execute, then one of the
	// memory, multiply or divide tails before the result is offered.
	mic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.stat(stat), .cmd(cmd)
	);

	// Hold architectural state and the result register.
	mic_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.instr(s_tdata), .cfg_data(cfg_data), .stat(stat),
		.fetch_addr(fetch_addr), .wb_valid(wb_valid), .wb_reg(wb_reg),
		.wb_value(wb_value), .event_kind(m_tuser), .event_value(event_value)
	);

	assign m_tdata = {2'b00, event_value, wb_value, wb_reg, wb_valid, fetch_addr};

	// A result is never offered while an instruction is being taken.
	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("result offered while accepting");

	// An accepted instruction always leaves the idle state.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("still ready after accept");

	// A taken result returns the core to idle.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
		else $error("not idle after result transaction");

	// Boot address writes only while idle.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> s_tready)
		else $error("config ready while busy");

endmodule

// ===== verif/tb_mips_integer_core_step.sv =====
// ----------------------------------------------------------------------------
// tb_mips_integer_core_step - self-checking bench for the multicycle MIPS core
// Streams instruction words into the core under several boot addresses. A
// scoreboard keeps its own copy of the architectural state, predicts the result
// of every accepted instruction, and compares the returned results in order.
// ----------------------------------------------------------------------------
module tb_mips_integer_core_step
	import mic_pkg::*;
();

	localparam int CLK_LIMIT = 400000;

	// one predicted or observed result transaction
	typedef struct packed {
		logic [31:0] fetch_addr;
		logic        wb_valid;
		logic [4:0]  wb_reg;
		logic [31:0] wb_value;
		event_t      ev_kind;
		logic [31:0] ev_value;
	} outcome_t;

	// Architectural shadow of the core plus the queue of pending outcomes.
	class core_scoreboard;
		logic [31:0] pc;
		logic [31:0] gpr [32];
		logic [31:0] hi, lo;
		logic [31:0] dmem [DMEM_WORDS];
		logic        halted;
		outcome_t    pending [$];
		int          errors;
		int          checked;

		function new();
			pc = '0;
			hi = '0;
			lo = '0;
			halted = 1'b0;
			errors = 0;
			checked = 0;
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
		endfunction

		function void set_boot(logic [31:0] v);
			pc = {v[31:2], 2'b00};
		endfunction

		// work out the outcome of one instruction and advance the shadow state
		function void note(logic [31:0] w);
			outcome_t    r;
			logic [5:0]  op, fn;
			logic [4:0]  rs, rt, rd, sa;
			logic [31:0] a, b, simm, zimm, addr, npc, q, rm, ma, mb, cur;
			logic [63:0] p;
			int unsigned idx;
			op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
			sa = w[10:6]; fn = w[5:0];
			zimm = {16'h0, w[15:0]};
			simm = {{16{w[15]}}, w[15:0]};
			r = '0;
			r.ev_kind = EV_NONE;
			if (halted) begin
				r.ev_kind = EV_HALT;
				r.fetch_addr = pc;
				pending.push_back(r);
				return;
			end
			a = gpr[rs];
			b = gpr[rt];
			npc = pc + 32'd4;
			addr = a + simm;
			idx = (addr >> 2) % DMEM_WORDS;
			cur = dmem[idx];
			pc = npc;
			if (op == OP_RTYPE) begin
				case (fn)
					FN_SLL: wr(r, rd, b << sa);
					FN_SRL: wr(r, rd, b >> sa);
					FN_SRA: wr(r, rd, $unsigned($signed(b) >>> sa));
					FN_JR: pc = a;
					FN_SYSCALL: begin
						if (gpr[REG_V0] == SYS_PRINT_INT) begin
							r.ev_kind = EV_INT; r.ev_value = gpr[REG_A0];
						end else if (gpr[REG_V0] == SYS_PRINT_CHAR) begin
							r.ev_kind = EV_CHAR; r.ev_value = gpr[REG_A0];
						end else if (gpr[REG_V0] == SYS_EXIT) begin
							r.ev_kind = EV_HALT; halted = 1'b1;
						end
					end
					FN_MFHI: wr(r, rd, hi);
					FN_MFLO: wr(r, rd, lo);
					FN_MULT: begin
						p = longint'($signed(a)) * longint'($signed(b));
						hi = p[63:32]; lo = p[31:0];
					end
					FN_MULTU: begin
						p = {32'h0, a} * {32'h0, b};
						hi = p[63:32]; lo = p[31:0];
					end
					FN_DIV: if (b != 0) begin
						// divide magnitudes, then fix up the signs
						ma = a[31] ? -a : a;
						mb = b[31] ? -b : b;
						q = ma / mb;
						rm = ma % mb;
						if (a[31] ^ b[31]) q = -q;
						if (a[31]) rm = -rm;
						lo = q; hi = rm;
					end
					FN_DIVU: if (b != 0) begin
						lo = a / b; hi = a % b;
					end
					FN_ADD, FN_ADDU: wr(r, rd, a + b);
					FN_SUB, FN_SUBU: wr(r, rd, a - b);
					FN_AND: wr(r, rd, a & b);
					FN_OR:  wr(r, rd, a | b);
					FN_NOR: wr(r, rd, ~(a | b));
					FN_SLT: wr(r, rd, {31'h0, $signed(a) < $signed(b)});
					FN_SLTU: wr(r, rd, {31'h0, a < b});
					default: ;
				endcase
			end else begin
				case (op)
					OP_J: pc = {npc[31:28], w[25:0], 2'b00};
					OP_JAL: begin
						wr(r, REG_RA, npc);
						pc = {npc[31:28], w[25:0], 2'b00};
					end
					OP_BEQ: if (a == b) pc = npc + (simm << 2);
					OP_BNE: if (a != b) pc = npc + (simm << 2);
					OP_ADDI, OP_ADDI_U: wr(r, rt, a + simm);
					OP_SLTI:   wr(r, rt, {31'h0, $signed(a) < $signed(simm)});
					OP_SLTI_U: wr(r, rt, {31'h0, a < simm});
					OP_ANDI: wr(r, rt, a & zimm);
					OP_ORI:  wr(r, rt, a | zimm);
					OP_LUI:  wr(r, rt, {w[15:0], 16'h0});
					OP_LW:   wr(r, rt, cur);
					// big-endian: byte 0 sits in the top lane
					OP_LBU: wr(r, rt, (cur >> ((3 - addr[1:0]) * 8)) & 32'hFF);
					OP_LHU: wr(r, rt, addr[1] ? (cur & 32'hFFFF) : (cur >> 16));
					OP_SB: begin
						cur[(3 - addr[1:0]) * 8 +: 8] = b[7:0];
						dmem[idx] = cur;
					end
					OP_SH: begin
						if (addr[1]) cur[15:0] = b[15:0];
						else cur[31:16] = b[15:0];
						dmem[idx] = cur;
					end
					OP_SW: dmem[idx] = b;
					default: ;
				endcase
			end
			r.fetch_addr = pc;
			pending.push_back(r);
		endfunction

		// register write; r0 swallows it
		function void wr(inout outcome_t r, input logic [4:0] d, input logic [31:0] v);
			if (d == 0) return;
			gpr[d] = v;
			r.wb_valid = 1'b1;
			r.wb_reg = d;
			r.wb_value = v;
		endfunction

		function void check(outcome_t got);
			outcome_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result transaction, got %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.fetch_addr !== exp_r.fetch_addr) begin
				$display("%0t: fetch_addr exp %h got %h", $time, exp_r.fetch_addr,
					got.fetch_addr);
				errors++;
			end
			if (got.wb_valid !== exp_r.wb_valid) begin
				$display("%0t: wb_valid exp %b got %b", $time, exp_r.wb_valid, got.wb_valid);
				errors++;
			end
			if (got.wb_reg !== exp_r.wb_reg) begin
				$display("%0t: wb_reg exp %0d got %0d", $time, exp_r.wb_reg, got.wb_reg);
				errors++;
			end
			if (got.wb_value !== exp_r.wb_value) begin
				$display("%0t: wb_value exp %h got %h", $time, exp_r.wb_value, got.wb_value);
				errors++;
			end
			if (got.ev_kind !== exp_r.ev_kind) begin
				$display("%0t: event_kind exp %0d got %0d", $time, exp_r.ev_kind,
					got.ev_kind);
				errors++;
			end
			if (got.ev_value !== exp_r.ev_value) begin
				$display("%0t: event_value exp %h got %h", $time, exp_r.ev_value,
					got.ev_value);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;

	core_scoreboard sb;
	int             cycles;
	int             sent;
	bit             busy_mode;  // when set, neither side idles

	mips_integer_core_step uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// watchdog: the slowest legal run stays far below this
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CLK_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("mips_integer_core_step verification failed");
			$finish;
		end
	end

	// compare every completed result transaction with the oldest prediction
	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.fetch_addr = m_tdata[31:0];
			got.wb_valid   = m_tdata[32];
			got.wb_reg     = m_tdata[37:33];
			got.wb_value   = m_tdata[69:38];
			got.ev_value   = m_tdata[101:70];
			got.ev_kind    = event_t'(m_tuser);
			sb.check(got);
		end
	end

	// result side: drop tready for a random stall after each transaction
	initial begin
		int n;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			n = busy_mode ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// hold the instruction until the core takes it, then log it
	task automatic send_instr(logic [31:0] w);
		int gap;
		gap = busy_mode ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		sb.note(w);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_boot(logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_boot(v);
	endtask

	function automatic logic [31:0] enc_r(int rs, int rt, int rd, int sa, logic [5:0] fn);
		return {OP_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'(sa), fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, int rs, int rt, logic [15:0] imm);
		return {op, 5'(rs), 5'(rt), imm};
	endfunction

	// mostly well-formed instructions on a small register window, some raw noise
	function automatic logic [31:0] rand_instr();
		logic [5:0] ops [17] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDI_U,
			OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_LBU, OP_LHU,
			OP_SB, OP_SH, OP_SW};
		logic [5:0] fns [19] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_SYSCALL, FN_MFHI,
			FN_MFLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB,
			FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLT};
		logic [31:0] w;
		int          sel;
		sel = $urandom_range(0, 99);
		w = $urandom();
		if (sel < 10) begin
			// raw word, any encoding
		end else if (sel < 18) begin
			// print call: point v0 at a print code or fire the syscall
			w = ($urandom_range(0, 1)) ?
				enc_i(OP_ADDI_U, 0, 2, $urandom_range(0, 1) ? 16'(SYS_PRINT_INT)
					: 16'(SYS_PRINT_CHAR)) :
				enc_r(0, 0, 0, 0, FN_SYSCALL);
		end else begin
			w[25:21] = 5'($urandom_range(0, 7));
			w[20:16] = 5'($urandom_range(0, 7));
			if (sel < 55) begin
				w[31:26] = OP_RTYPE;
				w[15:11] = 5'($urandom_range(0, 8));
				w[5:0]   = ($urandom_range(0, 19) == 19) ? FN_SLTU : fns[$urandom_range(0, 18)];
			end else begin
				w[31:26] = ops[$urandom_range(0, 16)];
			end
		end
		// keep the core running: no stop request before the final phase
		if (w[31:26] == OP_RTYPE && w[5:0] == FN_SYSCALL && sb.gpr[REG_V0] == SYS_EXIT)
			w[5:0] = FN_SLL;
		return w;
	endfunction

	task automatic random_run(int count);
		repeat (count) send_instr(rand_instr());
	endtask

	initial begin
		logic [31:0] directed [$];
		sb = new();
		cycles = 0;
		sent = 0;
		busy_mode = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: operand extremes, every operation but ADDU and SUBU, each corner case.
		directed = '{
			enc_i(OP_LUI, 0, 8, 16'h8000),          // r8 = most negative
			enc_i(OP_ORI, 0, 9, 16'hFFFF),          // r9 = 0x0000ffff
			enc_i(OP_ADDI_U, 0, 10, 16'hFFFF),      // r10 = -1
			enc_r(8, 10, 11, 0, FN_ADD),            // wraps, no trap
			enc_r(8, 9, 12, 0, FN_SUB),
			enc_r(8, 10, 13, 0, FN_SLT),
			enc_r(8, 10, 13, 0, FN_SLTU),
			enc_i(OP_SLTI_U, 0, 14, 16'hFFFF),      // sign-extended, unsigned compare
			enc_i(OP_SLTI, 8, 14, 16'h0001),
			enc_r(0, 10, 15, 31, FN_SLL),
			enc_r(0, 8, 15, 31, FN_SRA),
			enc_r(0, 10, 15, 31, FN_SRL),
			enc_r(8, 10, 0, 0, FN_MULT),            // full product
			enc_r(0, 0, 16, 0, FN_MFHI),
			enc_r(10, 10, 0, 0, FN_MULTU),
			enc_r(8, 10, 0, 0, FN_DIV),             // most negative over -1
			enc_r(0, 0, 17, 0, FN_MFLO),
			enc_r(8, 0, 0, 0, FN_DIVU),             // divide by zero keeps HI/LO
			enc_r(0, 0, 17, 0, FN_MFHI),
			enc_i(OP_SW, 10, 10, 16'hFFFF),         // unaligned, wraps round memory
			enc_i(OP_SB, 0, 9, 16'h0001),
			enc_i(OP_SH, 0, 8, 16'h0003),
			enc_i(OP_LW, 0, 18, 16'h0002),
			enc_i(OP_LBU, 0, 18, 16'h0001),
			enc_i(OP_LHU, 0, 18, 16'h0000),
			enc_i(OP_ADDI, 9, 0, 16'h7FFF),         // write to r0 dropped
			enc_r(8, 9, 19, 0, FN_NOR),
			enc_i(OP_ANDI, 10, 19, 16'h8001),
			enc_r(9, 10, 19, 0, FN_AND),
			enc_r(9, 10, 19, 0, FN_OR),
			enc_i(OP_BEQ, 0, 0, 16'h8000),
			enc_i(OP_BNE, 8, 9, 16'h7FFF),
			{OP_J, 26'h3FFFFFF},
			{OP_JAL, 26'h0000001},
			enc_r(9, 0, 0, 0, FN_JR),               // odd target taken as is
			32'hFC00_0000,                          // unknown opcode
			enc_r(0, 0, 20, 0, 6'd63),              // unknown function
			enc_r(0, 0, 0, 0, FN_SYSCALL),          // v0 = 0: nothing
			enc_i(OP_ADDI_U, 0, 2, 16'(SYS_PRINT_INT)),
			enc_r(0, 0, 0, 0, FN_SYSCALL),
			enc_i(OP_ADDI_U, 0, 2, 16'(SYS_PRINT_CHAR)),
			enc_r(0, 0, 0, 0, FN_SYSCALL)
		};
		write_boot(32'h0000_0000);
		foreach (directed[i]) send_instr(directed[i]);
		drain();

		// boot address extremes and mid values; low bits must be cleared
		write_boot(32'hFFFF_FFFF);
		random_run(170);
		drain();
		busy_mode = 1'b1;
		write_boot($urandom());
		random_run(170);
		drain();
		busy_mode = 1'b0;
		write_boot(32'h0040_0002);
		random_run(170);

		// stop the core, then confirm further words are ignored
		send_instr(enc_i(OP_ADDI_U, 0, 2, 16'(SYS_EXIT)));
		send_instr(enc_r(0, 0, 0, 0, FN_SYSCALL));
		repeat (4) send_instr($urandom());
		drain();

		$display("%0d instructions under four boot addresses, %0d results checked,",
			sent, sb.checked);
		$display("directed corner cases, random programs and halt handling covered");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("mips_integer_core_step verification clean");
		else
			$display("mips_integer_core_step verification failed");
		$finish;
	end

endmodule
